// ===== design/pstk_pkg.sv =====
// Package for the priority stack: operation codes, error codes and the
// command struct that the top level hands to every cell of the chain.
// No dependencies.
package pstk_pkg;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    localparam int VALUE_W = 32;
    localparam int PRIO_PORT_W = 8;

    // Command broadcast to all cells in the cycle an item is accepted.
    typedef struct packed {
        logic push;
        logic pop;
    } cmd_t;

endpackage

// ===== design/pstk_cell.sv =====
// One slot of the sorted chain: a valid bit, an element and its priority.
// Depends on pstk_pkg for the command struct and the element width.
module pstk_cell #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pstk_pkg::cmd_t             cmd,
    input  logic [31:0]                new_value,
    input  logic [PRIORITY_BITS-1:0]   new_prio,
    input  logic                       left_gt,
    input  logic                       left_valid,
    input  logic [31:0]                left_value,
    input  logic [PRIORITY_BITS-1:0]   left_prio,
    input  logic                       right_valid,
    input  logic [31:0]                right_value,
    input  logic [PRIORITY_BITS-1:0]   right_prio,
    output logic                       valid,
    output logic [31:0]                value,
    output logic [PRIORITY_BITS-1:0]   prio,
    output logic                       gt,
    output logic                       valid_next,
    output logic [31:0]                value_next,
    output logic [PRIORITY_BITS-1:0]   prio_next
);
    import pstk_pkg::*;

    logic                     valid_reg;
    logic [VALUE_W-1:0]       value_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;

    // This slot outranks the incoming element and stays where it is.
    assign gt = valid_reg && (prio_reg > new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.push)
        begin
            if (!gt && left_gt)
            begin
                valid_next = 1'b1;
                value_next = new_value;
                prio_next  = new_prio;
            end
            else if (!gt && left_valid)
            begin
                valid_next = 1'b1;
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (cmd.pop)
        begin
            valid_next = right_valid;
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// ===== design/priority_stack_unit.sv =====
// Top level of the priority stack: a chain of pstk_cell slots, the entry
// count and the result register. Depends on pstk_pkg and pstk_cell.
//
// Usage. Each input beat carries func (push, pop or query), push_value and
// push_priority. Each accepted beat yields exactly one output beat with the
// top element and its priority after the operation (zero when empty), the
// entry count, an empty flag and an error code (pop on empty, push on full).
// Entries are kept sorted with the highest priority in slot 0; a push lands
// above every entry of equal or lower priority, so ties leave last-in
// first-out.
// The result beat is valid in the cycle after the input beat is accepted.
// Throughput is one beat per cycle while the receiver does not stall, because
// every cell compares its own priority with the incoming one in parallel and
// all cells shift to their neighbors together; the result register is the only
// stage between the two channels.
// When the receiver stalls, the result register holds its beat and in_stall
// is raised, so no further input is taken until the result is taken.
// Reset clears all valid bits, the count and the result valid flag; the
// stored elements and the result fields are not cleared, since empty slots
// are never read and the fields only count while out_valid is high.
module priority_stack_unit #(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [31:0]                     push_value,
    input  logic [7:0]                      push_priority,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     top_value,
    output logic [7:0]                      top_priority,
    output logic [$clog2(DEPTH+1)-1:0]      count,
    output logic                            is_empty,
    output logic [1:0]                      error
);
    import pstk_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     in_accept;
    logic                     is_full;
    logic                     store_empty;
    logic                     func_push;
    logic                     func_pop;
    cmd_t                     cmd;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [1:0]               err;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    logic                     out_valid_reg;
    logic [VALUE_W-1:0]       top_value_reg;
    logic [PRIO_PORT_W-1:0]   top_priority_reg;
    logic [CNT_W-1:0]         count_out_reg;
    logic                     is_empty_reg;
    logic [1:0]               error_reg;

    // Chain wiring, one element per cell.
    logic                     cell_valid      [DEPTH];
    logic [VALUE_W-1:0]       cell_value      [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio       [DEPTH];
    logic                     cell_gt         [DEPTH];
    logic                     cell_valid_next [DEPTH];
    logic [VALUE_W-1:0]       cell_value_next [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio_next  [DEPTH];

    // A new beat is taken whenever the result register is free or is
    // being emptied in this cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign is_full     = (count_reg == CNT_W'(DEPTH));
    assign store_empty = (count_reg == '0);
    assign new_prio    = PRIORITY_BITS'(push_priority);

    always_comb
    begin
        func_push = 1'b0;
        func_pop  = 1'b0;
        case (func)
            FUNC_PUSH: func_push = 1'b1;
            FUNC_POP:  func_pop  = 1'b1;
            default:   ;
        endcase
    end

    // Illegal operations are turned into queries before they reach the chain.
    assign cmd.push = in_accept && func_push && !is_full;
    assign cmd.pop  = in_accept && func_pop && !store_empty;

    always_comb
    begin
        err = ERR_NONE;
        if (func_push && is_full)
        begin
            err = ERR_FULL;
        end
        else if (func_pop && store_empty)
        begin
            err = ERR_EMPTY;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                     l_gt;
            logic                     l_valid;
            logic [VALUE_W-1:0]       l_value;
            logic [PRIORITY_BITS-1:0] l_prio;
            logic                     r_valid;
            logic [VALUE_W-1:0]       r_value;
            logic [PRIORITY_BITS-1:0] r_prio;

            if (gi == 0)
            begin : g_head
                // Nothing sits above slot 0, so it behaves as if outranked.
                assign l_gt    = 1'b1;
                assign l_valid = 1'b0;
                assign l_value = '0;
                assign l_prio  = '0;
            end
            else
            begin : g_mid_l
                assign l_gt    = cell_gt[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_prio  = cell_prio[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_value = '0;
                assign r_prio  = '0;
            end
            else
            begin : g_mid_r
                assign r_valid = cell_valid[gi+1];
                assign r_value = cell_value[gi+1];
                assign r_prio  = cell_prio[gi+1];
            end

            pstk_cell #(
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .new_value   (push_value),
                .new_prio    (new_prio),
                .left_gt     (l_gt),
                .left_valid  (l_valid),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_valid (r_valid),
                .right_value (r_value),
                .right_prio  (r_prio),
                .valid       (cell_valid[gi]),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi]),
                .gt          (cell_gt[gi]),
                .valid_next  (cell_valid_next[gi]),
                .value_next  (cell_value_next[gi]),
                .prio_next   (cell_prio_next[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result reflects the state after the operation, taken from the
    // next value of slot 0.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            top_value_reg    <= cell_valid_next[0] ? cell_value_next[0] : '0;
            top_priority_reg <= cell_valid_next[0] ?
                                PRIO_PORT_W'(cell_prio_next[0]) : '0;
            count_out_reg    <= count_next;
            is_empty_reg     <= (count_next == '0);
            error_reg        <= err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_value    = top_value_reg;
    assign top_priority = top_priority_reg;
    assign count        = count_out_reg;
    assign is_empty     = is_empty_reg;
    assign error        = error_reg;

endmodule
